// ----- hdl/gqg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the glyph quad generator
package gqg_pkg;

    localparam int GLYPH_COUNT_DEF = 256;

    localparam int CODE_W  = 8;
    localparam int POS_W   = 16;
    localparam int EDGE_W  = 17;
    localparam int TEX_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LAYOUT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BOTTOM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd5;

    // quad corners in output order
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic [11:0] LINE_HEIGHT_RST = 12'd256;
    localparam logic [15:0] SCALE_RST       = 16'd4096;

    localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -16'sh8000;

    typedef struct packed {
        logic               operation;
        logic [7:0]         char_code;
        logic               start_text;
        logic signed [11:0] offset_x;
        logic signed [11:0] offset_y;
        logic [11:0]        glyph_width;
        logic [11:0]        glyph_height;
        logic [15:0]        tex_x;
        logic [15:0]        tex_y;
        logic [15:0]        tex_width;
        logic [15:0]        tex_height;
        logic [11:0]        advance;
    } in_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [1:0]         corner;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [11:0] line_height;
        logic [9:0]  pad_left;
        logic [9:0]  pad_top;
        logic [9:0]  pad_right;
        logic [9:0]  pad_bottom;
        logic [15:0] scale;
    } cfg_t;

    // one glyph table entry: geometry then texture rectangle
    typedef struct packed {
        logic signed [11:0] off_x;
        logic signed [11:0] off_y;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [11:0]        advance;
        logic [15:0]        tex_x;
        logic [15:0]        tex_y;
        logic [15:0]        tex_w;
        logic [15:0]        tex_h;
    } glyph_t;

    // one unscaled corner handed to the scaling pipeline
    typedef struct packed {
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
        logic [TEX_W-1:0]         u;
        logic [TEX_W-1:0]         v;
        logic [1:0]               corner;
        logic                     last;
    } vreq_t;

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [EDGE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > EDGE_W'(POS_MAX))
            r = POS_MAX;
        else if (v < EDGE_W'(POS_MIN))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/gqg_table.sv -----
`timescale 1ns / 1ps
// glyph table memory with per-entry present bits and registered read
module gqg_table #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [gqg_pkg::CODE_W-1:0]  code,
    input  gqg_pkg::glyph_t             wr_data,
    output gqg_pkg::glyph_t             rd_data,
    output logic                        rd_hit
);

    localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam logic [gqg_pkg::CODE_W:0] COUNT_LIM = (gqg_pkg::CODE_W + 1)'(GLYPH_COUNT);

    gqg_pkg::glyph_t glyph_mem [GLYPH_COUNT];

    logic [GLYPH_COUNT-1:0] present_reg;
    gqg_pkg::glyph_t        rd_data_reg;
    logic                   rd_hit_reg;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;

    assign in_range = ({1'b0, code} < COUNT_LIM);
    assign idx      = code[IDX_W-1:0];

    // codes past the table are dropped on load and read as absent
    always_ff @(posedge clk)
    begin
        if (wr_en && in_range)
            glyph_mem[idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= glyph_mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && in_range)
                present_reg[idx] <= 1'b1;
            if (rd_en)
                rd_hit_reg <= in_range && present_reg[idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

// ----- hdl/gqg_layout.sv -----
`timescale 1ns / 1ps
// pen tracking, quad edge build and corner sequencing
module gqg_layout (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gqg_pkg::cfg_t               cfg,
    input  logic                        take,
    input  logic [gqg_pkg::CODE_W-1:0]  take_code,
    input  logic                        take_start,
    output logic                        ready,
    input  gqg_pkg::glyph_t             glyph,
    input  logic                        glyph_hit,
    output logic                        vreq_valid,
    input  logic                        vreq_ready,
    output gqg_pkg::vreq_t              vreq
);

    localparam int EW = gqg_pkg::EDGE_W;
    localparam int TW = gqg_pkg::TEX_W;

    // lookup stage
    logic                        b_valid_reg;
    logic [gqg_pkg::CODE_W-1:0]  b_code_reg;
    logic                        b_start_reg;

    logic signed [gqg_pkg::POS_W-1:0] pen_x_reg, pen_y_reg;
    logic signed [gqg_pkg::POS_W-1:0] pen_x_next, pen_y_next;
    logic signed [gqg_pkg::POS_W-1:0] pen_x_base, pen_y_base;

    // corner stage
    logic       c_valid_reg;
    logic [1:0] corner_reg;
    logic signed [EW-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic [TW-1:0]        u0_reg, u1_reg, v0_reg, v1_reg;
    logic signed [EW-1:0] left_next, right_next, top_next, bottom_next;
    logic [TW-1:0]        u0_next, u1_next, v0_next, v1_next;

    logic                 newline;
    logic signed [EW-1:0] y_step, x_adv, x_org, y_org;
    logic                 c_free, b_leave, far_x, far_y;

    always_comb
    begin
        pen_x_base = b_start_reg ? '0 : pen_x_reg;
        pen_y_base = b_start_reg ? '0 : pen_y_reg;
        newline    = (b_code_reg == gqg_pkg::NEWLINE_CODE);
        y_step     = EW'(pen_y_base) + EW'(signed'({1'b0, cfg.line_height}));
        pen_y_next = newline ? gqg_pkg::sat16(y_step) : pen_y_base;
        pen_x_base = newline ? '0 : pen_x_base;

        // edges are exact in EDGE_W bits
        x_org       = EW'(pen_x_base) + EW'(glyph.off_x);
        y_org       = EW'(pen_y_next) + EW'(glyph.off_y);
        left_next   = x_org - EW'(signed'({1'b0, cfg.pad_left}));
        right_next  = x_org + EW'(signed'({1'b0, glyph.width}))
                            + EW'(signed'({1'b0, cfg.pad_right}));
        top_next    = y_org - EW'(signed'({1'b0, cfg.pad_top}));
        bottom_next = y_org + EW'(signed'({1'b0, glyph.height}))
                            + EW'(signed'({1'b0, cfg.pad_bottom}));
        u0_next     = TW'(glyph.tex_x);
        u1_next     = TW'(glyph.tex_x) + TW'(glyph.tex_w);
        v0_next     = TW'(glyph.tex_y);
        v1_next     = TW'(glyph.tex_y) + TW'(glyph.tex_h);

        x_adv      = EW'(pen_x_base) + EW'(signed'({1'b0, glyph.advance}));
        pen_x_next = glyph_hit ? gqg_pkg::sat16(x_adv) : pen_x_base;
    end

    assign c_free  = !c_valid_reg || (vreq_ready && (corner_reg == gqg_pkg::CORNER_BL));
    assign b_leave = b_valid_reg && (!glyph_hit || c_free);
    assign ready   = !b_valid_reg || b_leave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_code_reg  <= '0;
            b_start_reg <= 1'b0;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            c_valid_reg <= 1'b0;
            corner_reg  <= gqg_pkg::CORNER_TL;
        end
        else
        begin
            if (take)
            begin
                b_valid_reg <= 1'b1;
                b_code_reg  <= take_code;
                b_start_reg <= take_start;
            end
            else if (b_leave)
                b_valid_reg <= 1'b0;

            if (b_leave)
            begin
                pen_x_reg <= pen_x_next;
                pen_y_reg <= pen_y_next;
            end

            if (b_leave && glyph_hit)
            begin
                c_valid_reg <= 1'b1;
                corner_reg  <= gqg_pkg::CORNER_TL;
            end
            else if (c_valid_reg && vreq_ready)
            begin
                if (corner_reg == gqg_pkg::CORNER_BL)
                    c_valid_reg <= 1'b0;
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_leave && glyph_hit)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            u0_reg     <= u0_next;
            u1_reg     <= u1_next;
            v0_reg     <= v0_next;
            v1_reg     <= v1_next;
        end
    end

    assign far_x = (corner_reg == gqg_pkg::CORNER_TR) || (corner_reg == gqg_pkg::CORNER_BR);
    assign far_y = (corner_reg == gqg_pkg::CORNER_BR) || (corner_reg == gqg_pkg::CORNER_BL);

    assign vreq_valid  = c_valid_reg;
    assign vreq.x      = far_x ? right_reg : left_reg;
    assign vreq.y      = far_y ? bottom_reg : top_reg;
    assign vreq.u      = far_x ? u1_reg : u0_reg;
    assign vreq.v      = far_y ? v1_reg : v0_reg;
    assign vreq.corner = corner_reg;
    assign vreq.last   = (corner_reg == gqg_pkg::CORNER_BL);

endmodule

// ----- hdl/gqg_vertex.sv -----
`timescale 1ns / 1ps
// scale multiply, round to nearest and saturate, output register
module gqg_vertex (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     scale,
    input  logic            vreq_valid,
    output logic            vreq_ready,
    input  gqg_pkg::vreq_t  vreq,
    output logic            out_valid,
    input  logic            out_ready,
    output gqg_pkg::out_t   out_data
);

    localparam int EW     = gqg_pkg::EDGE_W;
    localparam int SCL_W  = 17;
    localparam int PROD_W = EW + SCL_W;
    localparam int FRAC_W = 12;
    localparam int Q_W    = PROD_W - FRAC_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);

    logic                     p_valid_reg, o_valid_reg;
    logic                     p_free, o_free;
    logic signed [SCL_W-1:0]  scale_s;
    logic signed [PROD_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [PROD_W-1:0] rx, ry;
    logic signed [Q_W-1:0]    qx, qy;
    gqg_pkg::vreq_t           p_side_reg;
    gqg_pkg::out_t            o_data_reg, o_data_next;

    function automatic logic signed [15:0] sat_q(input logic signed [Q_W-1:0] q);
        logic signed [15:0] r;
        if (q > Q_W'(gqg_pkg::POS_MAX))
            r = gqg_pkg::POS_MAX;
        else if (q < Q_W'(gqg_pkg::POS_MIN))
            r = gqg_pkg::POS_MIN;
        else
            r = q[15:0];
        return r;
    endfunction

    assign o_free     = !o_valid_reg || out_ready;
    assign p_free     = !p_valid_reg || o_free;
    assign vreq_ready = p_free;

    assign scale_s = signed'({1'b0, scale});
    assign px_next = PROD_W'(vreq.x) * PROD_W'(scale_s);
    assign py_next = PROD_W'(vreq.y) * PROD_W'(scale_s);

    // floor((p * scale + 2048) / 4096) is the tie-up rounding
    always_comb
    begin
        rx = px_reg + ROUND_HALF;
        ry = py_reg + ROUND_HALF;
        qx = rx[PROD_W-1:FRAC_W];
        qy = ry[PROD_W-1:FRAC_W];
        o_data_next.vertex_x = sat_q(qx);
        o_data_next.vertex_y = sat_q(qy);
        o_data_next.tex_u    = p_side_reg.u;
        o_data_next.tex_v    = p_side_reg.v;
        o_data_next.corner   = p_side_reg.corner;
        o_data_next.last     = p_side_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
                p_valid_reg <= vreq_valid;
            if (o_free)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && vreq_valid)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            p_side_reg <= vreq;
        end
        if (o_free && p_valid_reg)
            o_data_reg <= o_data_next;
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

// ----- hdl/glyph_quad_generator.sv -----
`timescale 1ns / 1ps
// top level: config registers, glyph table, layout and vertex pipeline
//
//  channel   signals                                direction  beat
//  in        in_valid  in_ready  in_data (in_t)     input      one load or one char
//  out       out_valid out_ready out_data (out_t)   output     one vertex
//  cfg       cfg_valid cfg_ready cfg_index cfg_data input      one register write
//
// a char beat reads the glyph table (registered sync read), then the pen is updated and
// the quad edges latched; the corner stage issues four vertices, one per cycle unless
// the vertex pipeline stalls, through a multiply stage and a round/saturate output register
// a drawn glyph holds the input while the corner stage is busy (the single vertex port);
// loads, absent glyphs and newlines without a glyph do not hold it; from accept to first
// vertex a char passes the table read, corner stage, multiply stage and output register
// reset clears the present bits, the pen and all valid flags; no clearing pass
// out_ready low stalls the pipeline back to in_ready; cfg_ready is always high
module glyph_quad_generator #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gqg_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gqg_pkg::out_t                   out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gqg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gqg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gqg_pkg::cfg_t   cfg_reg;
    gqg_pkg::glyph_t wr_glyph;
    gqg_pkg::glyph_t rd_glyph;
    gqg_pkg::vreq_t  vreq;
    logic            accept;
    logic            is_load, is_layout;
    logic            rd_hit;
    logic            vreq_valid, vreq_ready;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_height <= gqg_pkg::LINE_HEIGHT_RST;
            cfg_reg.pad_left    <= '0;
            cfg_reg.pad_top     <= '0;
            cfg_reg.pad_right   <= '0;
            cfg_reg.pad_bottom  <= '0;
            cfg_reg.scale       <= gqg_pkg::SCALE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gqg_pkg::CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[11:0];
                gqg_pkg::CFG_PAD_LEFT:    cfg_reg.pad_left    <= cfg_data[9:0];
                gqg_pkg::CFG_PAD_TOP:     cfg_reg.pad_top     <= cfg_data[9:0];
                gqg_pkg::CFG_PAD_RIGHT:   cfg_reg.pad_right   <= cfg_data[9:0];
                gqg_pkg::CFG_PAD_BOTTOM:  cfg_reg.pad_bottom  <= cfg_data[9:0];
                gqg_pkg::CFG_SCALE:       cfg_reg.scale       <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // input decode: loads write the table at accept, chars read it
    assign accept    = in_valid && in_ready;
    assign is_load   = accept && (in_data.operation == gqg_pkg::OP_LOAD);
    assign is_layout = accept && (in_data.operation == gqg_pkg::OP_LAYOUT);

    assign wr_glyph.off_x   = in_data.offset_x;
    assign wr_glyph.off_y   = in_data.offset_y;
    assign wr_glyph.width   = in_data.glyph_width;
    assign wr_glyph.height  = in_data.glyph_height;
    assign wr_glyph.advance = in_data.advance;
    assign wr_glyph.tex_x   = in_data.tex_x;
    assign wr_glyph.tex_y   = in_data.tex_y;
    assign wr_glyph.tex_w   = in_data.tex_width;
    assign wr_glyph.tex_h   = in_data.tex_height;

    gqg_table #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (is_load),
        .rd_en   (is_layout),
        .code    (in_data.char_code),
        .wr_data (wr_glyph),
        .rd_data (rd_glyph),
        .rd_hit  (rd_hit)
    );

    // pen and quad edges; a char in the lookup stage was read before any later load
    gqg_layout u_layout (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (is_layout),
        .take_code  (in_data.char_code),
        .take_start (in_data.start_text),
        .ready      (in_ready),
        .glyph      (rd_glyph),
        .glyph_hit  (rd_hit),
        .vreq_valid (vreq_valid),
        .vreq_ready (vreq_ready),
        .vreq       (vreq)
    );

    // scale, round and saturate each corner
    gqg_vertex u_vertex (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (cfg_reg.scale),
        .vreq_valid (vreq_valid),
        .vreq_ready (vreq_ready),
        .vreq       (vreq),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
